// File: rtl/hpwl_pkg.sv
package hpwl_pkg;

    localparam int NUM_BOUNDS = 4;

    // Slots of a bounding box
    localparam int BOX_XMIN = 0;
    localparam int BOX_XMAX = 1;
    localparam int BOX_YMIN = 2;
    localparam int BOX_YMAX = 3;

    // Per-pin net marks carried down the pipeline
    typedef struct packed {
        logic net_skip;
        logic last_pin;
        logic last_net;
    } t_net_tag;

endpackage

// File: rtl/hpwl_if.sv
interface hpwl_pin_if #(
    parameter int COORD_BITS = 24
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] pin_x;
    logic signed [COORD_BITS-1:0] pin_y;
    logic                         is_pad;
    logic                         net_skip;
    logic                         last_pin;
    logic                         last_net;

    modport source (
        output valid, pin_x, pin_y, is_pad, net_skip, last_pin, last_net,
        input  ready
    );
    modport sink (
        input  valid, pin_x, pin_y, is_pad, net_skip, last_pin, last_net,
        output ready
    );
endinterface

interface hpwl_res_if #(
    parameter int COORD_BITS = 24,
    parameter int TOTAL_BITS = 40
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS:0]   net_length_all;
    logic [COORD_BITS:0]   net_length_no_pads;
    logic [TOTAL_BITS-1:0] total_with_pads;
    logic [TOTAL_BITS-1:0] total_limited;
    logic [TOTAL_BITS-1:0] total_without_pads;
    logic                  sweep_done;

    modport source (
        output valid, net_length_all, net_length_no_pads, total_with_pads,
               total_limited, total_without_pads, sweep_done,
        input  ready
    );
    modport sink (
        input  valid, net_length_all, net_length_no_pads, total_with_pads,
               total_limited, total_without_pads, sweep_done,
        output ready
    );
endinterface

// File: rtl/net_hpwl_accumulator.sv
// Half-perimeter wirelength accumulator. Feed one pin per item on i_pin; the
// pin flagged last_pin closes its net and yields one result on o_res with the
// net's half-perimeter over all pins, over non-pad pins (zero when the net has
// only pads), and three saturating running totals (all nets, nets whose
// net_skip is low on the last pin, and non-pad lengths). Totals clear after
// the result that carries sweep_done. The block sustains one pin per clock
// while the output is not stalled; a result goes through the pin, length and
// result stages in turn. Three register stages (pin, net length, result) each
// hold while the stage after is full. Under a stalled output, pins keep
// entering until a closed net waits in the length stage; from then on the
// input stalls too. The clock-period limit is set by the bounding-box merge
// feeding the length subtract and the combinational saturating total update.
module net_hpwl_accumulator #(
    parameter int COORD_BITS = 24,
    parameter int TOTAL_BITS = 40
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    hpwl_pin_if.sink          i_pin,
    hpwl_res_if.source        o_res
);
    import hpwl_pkg::*;

    localparam int LEN_BITS = COORD_BITS + 1;
    localparam int SUM_BITS = ((TOTAL_BITS > LEN_BITS) ? TOTAL_BITS : LEN_BITS) + 1;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic [LEN_BITS-1:0]          t_len;
    typedef logic [TOTAL_BITS-1:0]        t_total;

    function automatic logic [COORD_BITS-1:0] span(input t_coord hi, input t_coord lo);
        logic signed [LEN_BITS-1:0] d;
        d = LEN_BITS'(hi) - LEN_BITS'(lo);
        return d[COORD_BITS-1:0];
    endfunction

    function automatic t_total sat_add(input t_total a, input t_len b);
        logic [SUM_BITS-1:0] s;
        s = SUM_BITS'(a) + SUM_BITS'(b);
        if (s[SUM_BITS-1:TOTAL_BITS] != '0) begin
            return '1;
        end
        return s[TOTAL_BITS-1:0];
    endfunction

    // pin stage
    logic     r_in_valid;
    t_coord   r_in_x;
    t_coord   r_in_y;
    logic     r_in_pad;
    t_net_tag r_in_tag;

    // net box state
    t_coord   r_box_all  [NUM_BOUNDS];
    t_coord   r_box_core [NUM_BOUNDS];
    t_coord   n_box_all  [NUM_BOUNDS];
    t_coord   n_box_core [NUM_BOUNDS];
    logic     r_net_started;
    logic     r_core_started;
    logic     core_valid;

    // length stage
    logic     r_len_valid;
    t_len     r_len_all;
    t_len     r_len_core;
    t_net_tag r_len_tag;
    t_len     n_len_all;
    t_len     n_len_core;

    // result stage and totals
    logic     r_out_valid;
    t_len     r_out_len_all;
    t_len     r_out_len_core;
    t_total   r_out_sum_all;
    t_total   r_out_sum_lim;
    t_total   r_out_sum_core;
    logic     r_out_done;
    t_total   r_sum_all;
    t_total   r_sum_lim;
    t_total   r_sum_core;
    t_total   n_sum_all;
    t_total   n_sum_lim;
    t_total   n_sum_core;

    logic     out_ready;
    logic     len_ready;
    logic     in_ready;
    logic     in_fire;
    logic     mid_fire;
    logic     len_fire;

    assign out_ready = !r_out_valid || o_res.ready;
    assign len_ready = !r_len_valid || out_ready;
    assign in_ready  = !r_in_valid || len_ready;
    assign in_fire   = i_pin.valid && in_ready;
    assign mid_fire  = r_in_valid && len_ready;
    assign len_fire  = r_len_valid && out_ready;

    assign i_pin.ready = in_ready;

    // merge the pin into both boxes; a fresh box takes the pin as is
    always_comb begin
        n_box_all[BOX_XMIN] = (!r_net_started || r_in_x < r_box_all[BOX_XMIN]) ?
                              r_in_x : r_box_all[BOX_XMIN];
        n_box_all[BOX_XMAX] = (!r_net_started || r_in_x > r_box_all[BOX_XMAX]) ?
                              r_in_x : r_box_all[BOX_XMAX];
        n_box_all[BOX_YMIN] = (!r_net_started || r_in_y < r_box_all[BOX_YMIN]) ?
                              r_in_y : r_box_all[BOX_YMIN];
        n_box_all[BOX_YMAX] = (!r_net_started || r_in_y > r_box_all[BOX_YMAX]) ?
                              r_in_y : r_box_all[BOX_YMAX];

        n_box_core = r_box_core;
        if (!r_in_pad) begin
            n_box_core[BOX_XMIN] = (!r_core_started || r_in_x < r_box_core[BOX_XMIN]) ?
                                   r_in_x : r_box_core[BOX_XMIN];
            n_box_core[BOX_XMAX] = (!r_core_started || r_in_x > r_box_core[BOX_XMAX]) ?
                                   r_in_x : r_box_core[BOX_XMAX];
            n_box_core[BOX_YMIN] = (!r_core_started || r_in_y < r_box_core[BOX_YMIN]) ?
                                   r_in_y : r_box_core[BOX_YMIN];
            n_box_core[BOX_YMAX] = (!r_core_started || r_in_y > r_box_core[BOX_YMAX]) ?
                                   r_in_y : r_box_core[BOX_YMAX];
        end

        core_valid = r_core_started || !r_in_pad;

        n_len_all = LEN_BITS'(span(n_box_all[BOX_XMAX], n_box_all[BOX_XMIN]))
                  + LEN_BITS'(span(n_box_all[BOX_YMAX], n_box_all[BOX_YMIN]));
        if (core_valid) begin
            n_len_core = LEN_BITS'(span(n_box_core[BOX_XMAX], n_box_core[BOX_XMIN]))
                       + LEN_BITS'(span(n_box_core[BOX_YMAX], n_box_core[BOX_YMIN]));
        end else begin
            n_len_core = '0;
        end
    end

    always_comb begin
        n_sum_all  = sat_add(r_sum_all, r_len_all);
        n_sum_lim  = r_len_tag.net_skip ? r_sum_lim : sat_add(r_sum_lim, r_len_all);
        n_sum_core = sat_add(r_sum_core, r_len_core);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (mid_fire) begin
            r_in_valid <= 1'b0;
        end
        if (in_fire) begin
            r_in_x            <= i_pin.pin_x;
            r_in_y            <= i_pin.pin_y;
            r_in_pad          <= i_pin.is_pad;
            r_in_tag.net_skip <= i_pin.net_skip;
            r_in_tag.last_pin <= i_pin.last_pin;
            r_in_tag.last_net <= i_pin.last_net;
        end
    end

    // advance the net box; drop it once the net closes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_net_started  <= 1'b0;
            r_core_started <= 1'b0;
        end else if (mid_fire) begin
            r_net_started  <= !r_in_tag.last_pin;
            r_core_started <= !r_in_tag.last_pin && core_valid;
        end
        if (mid_fire) begin
            r_box_all  <= n_box_all;
            r_box_core <= n_box_core;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_valid <= 1'b0;
        end else if (mid_fire) begin
            r_len_valid <= r_in_tag.last_pin;
        end else if (len_fire) begin
            r_len_valid <= 1'b0;
        end
        if (mid_fire) begin
            r_len_all  <= n_len_all;
            r_len_core <= n_len_core;
            r_len_tag  <= r_in_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sum_all   <= '0;
            r_sum_lim   <= '0;
            r_sum_core  <= '0;
        end else begin
            if (len_fire) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (len_fire) begin
                if (r_len_tag.last_net) begin
                    r_sum_all  <= '0;
                    r_sum_lim  <= '0;
                    r_sum_core <= '0;
                end else begin
                    r_sum_all  <= n_sum_all;
                    r_sum_lim  <= n_sum_lim;
                    r_sum_core <= n_sum_core;
                end
            end
        end
        if (len_fire) begin
            r_out_len_all  <= r_len_all;
            r_out_len_core <= r_len_core;
            r_out_sum_all  <= n_sum_all;
            r_out_sum_lim  <= n_sum_lim;
            r_out_sum_core <= n_sum_core;
            r_out_done     <= r_len_tag.last_net;
        end
    end

    assign o_res.valid              = r_out_valid;
    assign o_res.net_length_all     = r_out_len_all;
    assign o_res.net_length_no_pads = r_out_len_core;
    assign o_res.total_with_pads    = r_out_sum_all;
    assign o_res.total_limited      = r_out_sum_lim;
    assign o_res.total_without_pads = r_out_sum_core;
    assign o_res.sweep_done         = r_out_done;

endmodule

// File: rtl/hpwl_chk.sv
module hpwl_chk #(
    parameter int COORD_BITS = 24,
    parameter int TOTAL_BITS = 40
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_res_valid,
    input logic                  i_res_ready,
    input logic [COORD_BITS:0]   i_len_all,
    input logic [COORD_BITS:0]   i_len_core,
    input logic [TOTAL_BITS-1:0] i_sum_all,
    input logic [TOTAL_BITS-1:0] i_sum_lim,
    input logic [TOTAL_BITS-1:0] i_sum_core,
    input logic                  i_done
);

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid right after reset");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_len_all)
            && $stable(i_len_core) && $stable(i_sum_all) && $stable(i_sum_lim)
            && $stable(i_sum_core) && $stable(i_done))
        else $error("stalled result changed");

    a_core_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> i_len_core <= i_len_all)
        else $error("non-pad length exceeds all-pin length");

    a_limited_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> i_sum_lim <= i_sum_all)
        else $error("limited total exceeds full total");

endmodule

bind net_hpwl_accumulator hpwl_chk #(
    .COORD_BITS (COORD_BITS),
    .TOTAL_BITS (TOTAL_BITS)
) u_hpwl_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_res_valid (o_res.valid),
    .i_res_ready (o_res.ready),
    .i_len_all   (o_res.net_length_all),
    .i_len_core  (o_res.net_length_no_pads),
    .i_sum_all   (o_res.total_with_pads),
    .i_sum_lim   (o_res.total_limited),
    .i_sum_core  (o_res.total_without_pads),
    .i_done      (o_res.sweep_done)
);

// File: verif/net_hpwl_accumulator_tb.sv
`timescale 1ns / 100ps

module net_hpwl_accumulator_tb;
    import hpwl_pkg::*;

    localparam int COORD_BITS  = 24;
    localparam int TOTAL_BITS  = 40;
    localparam int LEN_BITS    = COORD_BITS + 1;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASE_PINS  = 540;
    localparam int WIDE_NETS   = 40;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef t_coord t_box [NUM_BOUNDS];

    typedef struct {
        t_coord   x;
        t_coord   y;
        logic     is_pad;
        t_net_tag tag;
    } t_pin_item;

    typedef struct {
        logic [LEN_BITS-1:0]   len_all;
        logic [LEN_BITS-1:0]   len_core;
        logic [TOTAL_BITS-1:0] tot_all;
        logic [TOTAL_BITS-1:0] tot_limited;
        logic [TOTAL_BITS-1:0] tot_core;
        logic                  done;
    } t_net_report;

    class wirelength_board;
        t_box                  box_all;
        t_box                  box_core;
        bit                    net_open;
        bit                    core_open;
        logic [TOTAL_BITS-1:0] sum_all;
        logic [TOTAL_BITS-1:0] sum_limited;
        logic [TOTAL_BITS-1:0] sum_core;
        t_net_report           pending_nets[$];
        int                    mismatches;
        int                    nets_checked;
        int                    sweeps_closed;
        int                    saturated_nets;

        function t_box grown(t_box b, bit open, t_coord x, t_coord y);
            t_box r;
            r = b;
            if (!open) begin
                r[BOX_XMIN] = x;
                r[BOX_XMAX] = x;
                r[BOX_YMIN] = y;
                r[BOX_YMAX] = y;
            end else begin
                if (x < r[BOX_XMIN]) r[BOX_XMIN] = x;
                if (x > r[BOX_XMAX]) r[BOX_XMAX] = x;
                if (y < r[BOX_YMIN]) r[BOX_YMIN] = y;
                if (y > r[BOX_YMAX]) r[BOX_YMAX] = y;
            end
            return r;
        endfunction

        function logic [LEN_BITS-1:0] half_perimeter(t_box b, bit open);
            longint span;
            if (!open) return '0;
            span = (longint'(b[BOX_XMAX]) - longint'(b[BOX_XMIN]))
                 + (longint'(b[BOX_YMAX]) - longint'(b[BOX_YMIN]));
            return span[LEN_BITS-1:0];
        endfunction

        function logic [TOTAL_BITS-1:0] sat_sum(logic [TOTAL_BITS-1:0] a,
                                                logic [LEN_BITS-1:0] b);
            logic [TOTAL_BITS:0] s;
            s = {1'b0, a} + b;
            return s[TOTAL_BITS] ? '1 : s[TOTAL_BITS-1:0];
        endfunction

        function void note_pin(t_pin_item p);
            t_net_report r;
            box_all  = grown(box_all, net_open, p.x, p.y);
            net_open = 1'b1;
            if (!p.is_pad) begin
                box_core  = grown(box_core, core_open, p.x, p.y);
                core_open = 1'b1;
            end
            if (!p.tag.last_pin) return;
            r.len_all  = half_perimeter(box_all, 1'b1);
            r.len_core = half_perimeter(box_core, core_open);
            sum_all = sat_sum(sum_all, r.len_all);
            // only the skip flag on the closing pin matters
            if (!p.tag.net_skip) sum_limited = sat_sum(sum_limited, r.len_all);
            sum_core = sat_sum(sum_core, r.len_core);
            r.tot_all     = sum_all;
            r.tot_limited = sum_limited;
            r.tot_core    = sum_core;
            r.done        = p.tag.last_net;
            pending_nets.push_back(r);
            net_open  = 1'b0;
            core_open = 1'b0;
            if (p.tag.last_net) begin
                sum_all     = '0;
                sum_limited = '0;
                sum_core    = '0;
            end
        endfunction

        function void compare(string what, logic [63:0] want, logic [63:0] seen);
            if (seen !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("net %0d %s: expected %0d, got %0d",
                             nets_checked, what, want, seen);
            end
        endfunction

        function void check_net(t_net_report got);
            t_net_report want;
            if (pending_nets.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: length %0d, totals %0d/%0d/%0d",
                             got.len_all, got.tot_all, got.tot_limited, got.tot_core);
                return;
            end
            want = pending_nets.pop_front();
            compare("net_length_all", want.len_all, got.len_all);
            compare("net_length_no_pads", want.len_core, got.len_core);
            compare("total_with_pads", want.tot_all, got.tot_all);
            compare("total_limited", want.tot_limited, got.tot_limited);
            compare("total_without_pads", want.tot_core, got.tot_core);
            compare("sweep_done", want.done, got.done);
            nets_checked++;
            if (want.done) sweeps_closed++;
            if (&want.tot_all) saturated_nets++;
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    hpwl_pin_if #(.COORD_BITS(COORD_BITS)) pin_if ();
    hpwl_res_if #(.COORD_BITS(COORD_BITS), .TOTAL_BITS(TOTAL_BITS)) res_if ();

    net_hpwl_accumulator #(
        .COORD_BITS(COORD_BITS),
        .TOTAL_BITS(TOTAL_BITS)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_pin  (pin_if),
        .o_res  (res_if)
    );

    wirelength_board board;
    int send_idle;
    int recv_idle;
    int pins_sent;
    int cycles;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // result side: check on handshake, then pick next ready
    initial begin
        t_net_report got;
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (res_if.valid && res_if.ready) begin
                got.len_all     = res_if.net_length_all;
                got.len_core    = res_if.net_length_no_pads;
                got.tot_all     = res_if.total_with_pads;
                got.tot_limited = res_if.total_limited;
                got.tot_core    = res_if.total_without_pads;
                got.done        = res_if.sweep_done;
                board.check_net(got);
            end
            res_if.ready <= i_rst_n && ($urandom_range(99) >= recv_idle);
        end
    end

    function automatic t_pin_item make_pin(t_coord x, t_coord y, logic pad,
                                           logic skip, logic lastp, logic lastn);
        t_pin_item p;
        p.x = x;
        p.y = y;
        p.is_pad = pad;
        p.tag.net_skip = skip;
        p.tag.last_pin = lastp;
        p.tag.last_net = lastn;
        return p;
    endfunction

    task automatic send_pin(t_pin_item p);
        while ($urandom_range(99) < send_idle) begin
            pin_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        pin_if.valid    <= 1'b1;
        pin_if.pin_x    <= p.x;
        pin_if.pin_y    <= p.y;
        pin_if.is_pad   <= p.is_pad;
        pin_if.net_skip <= p.tag.net_skip;
        pin_if.last_pin <= p.tag.last_pin;
        pin_if.last_net <= p.tag.last_net;
        @(posedge i_clk);
        while (!pin_if.ready) @(posedge i_clk);
        board.note_pin(p);
        pins_sent++;
    endtask

    // hold the input until every closed net has reported
    task automatic drain();
        pin_if.valid <= 1'b0;
        @(posedge i_clk);
        while (board.pending_nets.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic t_coord pick_coord(t_coord center);
        case ($urandom_range(9))
            0:       return {1'b1, {(COORD_BITS-1){1'b0}}};
            1:       return {1'b0, {(COORD_BITS-1){1'b1}}};
            2:       return $urandom_range(1) ? '0 : '1;
            3, 4, 5: return t_coord'($urandom);
            default: return center + t_coord'($urandom_range(2000)) - t_coord'(1000);
        endcase
    endfunction

    task automatic send_random_net();
        int     n;
        int     pad_mode;
        t_coord center;
        logic   pad;
        logic   lastp;
        n = ($urandom_range(9) == 0) ? $urandom_range(24, 7) : $urandom_range(6, 1);
        pad_mode = $urandom_range(9);
        center = t_coord'($urandom);
        for (int i = 0; i < n; i++) begin
            lastp = (i == n - 1);
            case (pad_mode)
                0:       pad = 1'b1;
                1, 2, 3: pad = 1'b0;
                default: pad = ($urandom_range(99) < 30);
            endcase
            // last_net on an inner pin must be ignored
            send_pin(make_pin(pick_coord(center), pick_coord(center), pad,
                              1'($urandom_range(1)),
                              lastp,
                              lastp ? ($urandom_range(99) < 8) : ($urandom_range(9) == 0)));
        end
    endtask

    task automatic run_directed();
        t_coord lo;
        t_coord hi;
        lo = {1'b1, {(COORD_BITS-1){1'b0}}};
        hi = {1'b0, {(COORD_BITS-1){1'b1}}};
        // single pin: zero span
        send_pin(make_pin('0, '0, 1'b0, 1'b0, 1'b1, 1'b0));
        // opposite corners: widest span
        send_pin(make_pin(lo, lo, 1'b0, 1'b0, 1'b0, 1'b0));
        send_pin(make_pin(hi, hi, 1'b0, 1'b0, 1'b1, 1'b0));
        send_pin(make_pin(hi, lo, 1'b0, 1'b1, 1'b0, 1'b0));
        send_pin(make_pin(lo, hi, 1'b0, 1'b1, 1'b1, 1'b0));
        // pads only: core length zero
        send_pin(make_pin(lo, hi, 1'b1, 1'b0, 1'b0, 1'b0));
        send_pin(make_pin(hi, lo, 1'b1, 1'b1, 1'b1, 1'b0));
        send_pin(make_pin('1, '1, 1'b1, 1'b0, 1'b1, 1'b0));
        // skip raised early then dropped on the last pin
        send_pin(make_pin(24'sd100, -24'sd50, 1'b0, 1'b1, 1'b0, 1'b0));
        send_pin(make_pin(-24'sd300, 24'sd70, 1'b1, 1'b1, 1'b0, 1'b1));
        send_pin(make_pin(24'sd5, 24'sd9, 1'b0, 1'b0, 1'b1, 1'b0));
        // pads widen only the full box
        send_pin(make_pin(24'sd10, 24'sd10, 1'b0, 1'b0, 1'b0, 1'b0));
        send_pin(make_pin(lo, hi, 1'b1, 1'b0, 1'b0, 1'b0));
        send_pin(make_pin(24'sd20, -24'sd20, 1'b0, 1'b1, 1'b1, 1'b0));
        // close the sweep, then start a fresh one
        send_pin(make_pin(-24'sd1, 24'sd1, 1'b0, 1'b0, 1'b0, 1'b0));
        send_pin(make_pin(24'sd1, -24'sd1, 1'b0, 1'b0, 1'b1, 1'b1));
        send_pin(make_pin(hi, '0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_pin(make_pin('0, hi, 1'b0, 1'b0, 1'b1, 1'b0));
        send_pin(make_pin(24'sd3, 24'sd3, 1'b1, 1'b1, 1'b1, 1'b1));
    endtask

    // a burst of widest nets back to back, with some skipped, then clear
    task automatic run_wide_nets();
        t_coord lo;
        t_coord hi;
        lo = {1'b1, {(COORD_BITS-1){1'b0}}};
        hi = {1'b0, {(COORD_BITS-1){1'b1}}};
        for (int i = 0; i < WIDE_NETS; i++) begin
            send_pin(make_pin(lo, hi, 1'b0, 1'b1, 1'b0, 1'b0));
            send_pin(make_pin(hi, lo, 1'b0, (i % 7 == 0), 1'b1, i == WIDE_NETS - 1));
        end
    endtask

    initial begin
        int phase_start;
        int drain_at;
        board = new;
        pins_sent = 0;
        send_idle = 35;
        recv_idle = 53;
        i_rst_n = 1'b0;
        pin_if.valid    = 1'b0;
        pin_if.pin_x    = '0;
        pin_if.pin_y    = '0;
        pin_if.is_pad   = 1'b0;
        pin_if.net_skip = 1'b0;
        pin_if.last_pin = 1'b0;
        pin_if.last_net = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int ph = 0; ph < 3; ph++) begin
            send_idle = (ph == 0) ? 35 : (ph == 1) ? 53 : 0;
            recv_idle = (ph == 0) ? 53 : (ph == 1) ? 35 : 0;
            if (ph == 0) run_directed();
            phase_start = pins_sent;
            drain_at = $urandom_range(PHASE_PINS - 50, 50);
            while (pins_sent - phase_start < PHASE_PINS) begin
                send_random_net();
                if (drain_at > 0 && pins_sent - phase_start >= drain_at) begin
                    drain();
                    drain_at = 0;
                end
            end
            if (ph == 2) run_wide_nets();
            drain();
        end

        repeat (10) @(posedge i_clk);
        $display("Sent %0d pins, checked %0d net results over %0d closed sweeps.",
                 pins_sent, board.nets_checked, board.sweeps_closed);
        $display("%0d results carried saturated totals; %0d mismatches, %0d left open.",
                 board.saturated_nets, board.mismatches, board.pending_nets.size());
        if (board.mismatches == 0 && board.pending_nets.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
